>>> hdl/dsmmm_pkg.sv
// ----------------------------------------------------------------------------
// dsmmm_pkg
// shared constants and types for the dual sensor min/max/mean block
// ----------------------------------------------------------------------------
package dsmmm_pkg;

  // default sizes
  localparam int SAMPLE_BITS_DEF   = 13;
  localparam int FRACTION_BITS_DEF = 8;
  localparam int COUNT_BITS_DEF    = 32;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START_T,
    ST_WAIT_T,
    ST_START_H,
    ST_WAIT_H,
    ST_OUT
  } state_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hdl/dsmmm_div.sv
// ----------------------------------------------------------------------------
// dsmmm_div
// restoring serial divider, one quotient bit per cycle, unsigned operands
// ----------------------------------------------------------------------------
module dsmmm_div
  import dsmmm_pkg::*;
#(
  parameter int QW = SAMPLE_BITS_DEF + FRACTION_BITS_DEF,
  parameter int DW = COUNT_BITS_DEF + 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [QW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic [QW-1:0] quotient,
  output div_stat_t     stat
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] dvs_r, dvs_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [DW:0]   shifted;
  logic [DW:0]   trial;
  logic          fits;

  // one trial subtraction per cycle
  always_comb begin
    shifted = {rem_r, quo_r[QW-1]};
    fits    = (shifted >= {1'b0, dvs_r});
    trial   = shifted - {1'b0, dvs_r};
  end

  // step control
  always_comb begin
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? trial[DW-1:0] : shifted[DW-1:0];
      quo_nxt = {quo_r[QW-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // datapath flops
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> hdl/dual_sensor_min_max_mean_core.sv
// ----------------------------------------------------------------------------
// dual_sensor_min_max_mean_core
// running min, max and mean of paired humidity and temperature samples
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | humidity and temperature sample
//  out_    | output    | out_valid/out_stall| min, max, mean per channel, count
//
//  each word runs through the serial divider once per channel, temperature
//  first and humidity second, one quotient bit per cycle.
//  in_stall is high from accept until the result word is taken.
//  synchronous active-low reset clears all statistics and the sequencer.
//  out_stall holds the result word; statistics do not change meanwhile.
module dual_sensor_min_max_mean_core
  import dsmmm_pkg::*;
#(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [SAMPLE_BITS-1:0]               in_humidity_sample,
  input  logic [SAMPLE_BITS-1:0]               in_temperature_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [SAMPLE_BITS-1:0]               out_temperature_min,
  output logic [SAMPLE_BITS-1:0]               out_temperature_max,
  output logic [SAMPLE_BITS+FRACTION_BITS-1:0] out_temperature_mean,
  output logic [SAMPLE_BITS-1:0]               out_humidity_min,
  output logic [SAMPLE_BITS-1:0]               out_humidity_max,
  output logic [SAMPLE_BITS+FRACTION_BITS-1:0] out_humidity_mean,
  output logic [COUNT_BITS-1:0]                out_sample_count
);

  localparam int MW = SAMPLE_BITS + FRACTION_BITS;
  localparam int DW = COUNT_BITS + 1;

  state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] hum_r, tmp_r;
  logic [SAMPLE_BITS-1:0] temp_low_r, temp_low_nxt;
  logic [SAMPLE_BITS-1:0] temp_high_r, temp_high_nxt;
  logic [SAMPLE_BITS-1:0] hum_low_r, hum_low_nxt;
  logic [SAMPLE_BITS-1:0] hum_high_r, hum_high_nxt;
  logic [MW-1:0]          temp_avg_r, temp_avg_nxt;
  logic [MW-1:0]          hum_avg_r, hum_avg_nxt;
  logic [COUNT_BITS-1:0]  taken_r, taken_nxt;

  logic                   in_acc;
  logic                   div_start;
  div_stat_t              div_stat;
  logic [MW-1:0]          quotient;

  logic                   sel_temp;
  logic [SAMPLE_BITS-1:0] cur_sample;
  logic [MW-1:0]          cur_mean;
  logic [MW:0]            diff;
  logic                   diff_neg;
  logic [MW:0]            diff_abs;
  logic [MW-1:0]          new_mean;
  logic [DW-1:0]          divisor;
  logic                   first;

  assign in_acc = in_valid && !in_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_START_T;
      ST_START_T: state_nxt = ST_WAIT_T;
      ST_WAIT_T:  if (div_stat.done) state_nxt = ST_START_H;
      ST_START_H: state_nxt = ST_WAIT_H;
      ST_WAIT_H:  if (div_stat.done) state_nxt = ST_OUT;
      ST_OUT:     if (!out_stall) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE:    in_stall = 1'b0;
      ST_START_T: div_start = 1'b1;
      ST_START_H: div_start = 1'b1;
      ST_OUT:     out_valid = 1'b1;
      default:    ;
    endcase
  end

  // channel select and signed difference to the mean
  always_comb begin
    sel_temp   = (state_r == ST_START_T) || (state_r == ST_WAIT_T);
    cur_sample = sel_temp ? tmp_r : hum_r;
    cur_mean   = sel_temp ? temp_avg_r : hum_avg_r;
    diff       = ((MW + 1)'(cur_sample) << FRACTION_BITS) - {1'b0, cur_mean};
    diff_neg   = diff[MW];
    diff_abs   = diff_neg ? (~diff + 1'b1) : diff;
    new_mean   = diff_neg ? (cur_mean - quotient) : (cur_mean + quotient);
    divisor    = {1'b0, taken_r} + 1'b1;
    first      = (taken_r == '0);
  end

  // shared divider
  dsmmm_div #(
    .QW(MW),
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff_abs[MW-1:0]),
    .divisor  (divisor),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // statistics update
  always_comb begin
    temp_low_nxt  = temp_low_r;
    temp_high_nxt = temp_high_r;
    hum_low_nxt   = hum_low_r;
    hum_high_nxt  = hum_high_r;
    temp_avg_nxt  = temp_avg_r;
    hum_avg_nxt   = hum_avg_r;
    taken_nxt     = taken_r;
    if ((state_r == ST_WAIT_T) && div_stat.done) begin
      temp_avg_nxt = new_mean;
    end
    if ((state_r == ST_WAIT_H) && div_stat.done) begin
      hum_avg_nxt = new_mean;
      if (first || (tmp_r > temp_high_r)) temp_high_nxt = tmp_r;
      if (first || (tmp_r < temp_low_r))  temp_low_nxt  = tmp_r;
      if (first || (hum_r > hum_high_r))  hum_high_nxt  = hum_r;
      if (first || (hum_r < hum_low_r))   hum_low_nxt   = hum_r;
      if (taken_r != '1) taken_nxt = taken_r + 1'b1;
    end
  end

  // state and statistics flops
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      temp_low_r  <= '0;
      temp_high_r <= '0;
      hum_low_r   <= '0;
      hum_high_r  <= '0;
      temp_avg_r  <= '0;
      hum_avg_r   <= '0;
      taken_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      temp_low_r  <= temp_low_nxt;
      temp_high_r <= temp_high_nxt;
      hum_low_r   <= hum_low_nxt;
      hum_high_r  <= hum_high_nxt;
      temp_avg_r  <= temp_avg_nxt;
      hum_avg_r   <= hum_avg_nxt;
      taken_r     <= taken_nxt;
    end
  end

  // sample capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hum_r <= in_humidity_sample;
      tmp_r <= in_temperature_sample;
    end
  end

  assign out_temperature_min  = temp_low_r;
  assign out_temperature_max  = temp_high_r;
  assign out_temperature_mean = temp_avg_r;
  assign out_humidity_min     = hum_low_r;
  assign out_humidity_max     = hum_high_r;
  assign out_humidity_mean    = hum_avg_r;
  assign out_sample_count     = taken_r;

endmodule

>>> hdl/dsmmm_chk.sv
// ----------------------------------------------------------------------------
// dsmmm_chk
// port-level checks for the dual sensor min/max/mean block
// ----------------------------------------------------------------------------
module dsmmm_chk
  import dsmmm_pkg::*;
#(
  parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [SAMPLE_BITS-1:0]               out_temperature_min,
  input logic [SAMPLE_BITS-1:0]               out_temperature_max,
  input logic [SAMPLE_BITS+FRACTION_BITS-1:0] out_temperature_mean,
  input logic [SAMPLE_BITS-1:0]               out_humidity_min,
  input logic [SAMPLE_BITS-1:0]               out_humidity_max,
  input logic [SAMPLE_BITS+FRACTION_BITS-1:0] out_humidity_mean,
  input logic [COUNT_BITS-1:0]                out_sample_count
);

  // a stalled result word holds its valid, both means and the count
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_temperature_mean)
      && $stable(out_humidity_mean) && $stable(out_sample_count))
    else $error("stalled result word changed");

  // an accepted word keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after accept");

  // no input word is taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while result pending");

  // every result has seen a sample and keeps min at or below max
  a_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sample_count != '0)
      && (out_temperature_min <= out_temperature_max)
      && (out_humidity_min <= out_humidity_max))
    else $error("result word with bad count or min above max");

endmodule

bind dual_sensor_min_max_mean_core dsmmm_chk #(
  .SAMPLE_BITS   (SAMPLE_BITS),
  .FRACTION_BITS (FRACTION_BITS),
  .COUNT_BITS    (COUNT_BITS)
) u_dsmmm_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_temperature_min  (out_temperature_min),
  .out_temperature_max  (out_temperature_max),
  .out_temperature_mean (out_temperature_mean),
  .out_humidity_min     (out_humidity_min),
  .out_humidity_max     (out_humidity_max),
  .out_humidity_mean    (out_humidity_mean),
  .out_sample_count     (out_sample_count)
);

>>> bench/dual_sensor_min_max_mean_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_sensor_min_max_mean_core_tb
// self-checking bench for the dual sensor min/max/mean core: a queue-fed
// driver pushes paired samples, a local model of the running statistics
// predicts every result word, and a monitor checks each field in order
// ----------------------------------------------------------------------------
module dual_sensor_min_max_mean_core_tb;
  import dsmmm_pkg::*;

  localparam int SMP_W  = SAMPLE_BITS_DEF;
  localparam int FRAC_W = FRACTION_BITS_DEF;
  localparam int CNT_W  = COUNT_BITS_DEF;
  localparam int MEAN_W = SMP_W + FRAC_W;

  localparam int RANDOM_ITEMS = 1100;
  localparam int CALM_ITEMS   = 100;   // tail of the run with no idling
  localparam int SETTLE_CYCLES = 2 * MEAN_W + 20;

  localparam logic [SMP_W-1:0] SMP_TOP = '1;

  typedef struct packed {
    logic [SMP_W-1:0] hum;
    logic [SMP_W-1:0] temp;
  } sample_t;

  typedef struct packed {
    logic [SMP_W-1:0]  t_min;
    logic [SMP_W-1:0]  t_max;
    logic [MEAN_W-1:0] t_mean;
    logic [SMP_W-1:0]  h_min;
    logic [SMP_W-1:0]  h_max;
    logic [MEAN_W-1:0] h_mean;
    logic [CNT_W-1:0]  count;
  } stats_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [SMP_W-1:0]  in_humidity_sample = '0;
  logic [SMP_W-1:0]  in_temperature_sample = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [SMP_W-1:0]  out_temperature_min;
  logic [SMP_W-1:0]  out_temperature_max;
  logic [MEAN_W-1:0] out_temperature_mean;
  logic [SMP_W-1:0]  out_humidity_min;
  logic [SMP_W-1:0]  out_humidity_max;
  logic [MEAN_W-1:0] out_humidity_mean;
  logic [CNT_W-1:0]  out_sample_count;

  sample_t sample_queue[$];
  stats_t  stats_due[$];
  int      fault_count = 0;
  int      feed_gap = 0;
  int      hold_left = 0;
  logic    calm_tail = 1'b0;

  // running statistics as the block should hold them
  logic [SMP_W-1:0]  t_lo = '0, t_hi = '0, h_lo = '0, h_hi = '0;
  logic [MEAN_W-1:0] t_avg = '0, h_avg = '0;
  logic [CNT_W-1:0]  n_taken = '0;

  dual_sensor_min_max_mean_core DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_humidity_sample   (in_humidity_sample),
    .in_temperature_sample(in_temperature_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_temperature_min  (out_temperature_min),
    .out_temperature_max  (out_temperature_max),
    .out_temperature_mean (out_temperature_mean),
    .out_humidity_min     (out_humidity_min),
    .out_humidity_max     (out_humidity_max),
    .out_humidity_mean    (out_humidity_mean),
    .out_sample_count     (out_sample_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // one mean step: move toward the sample by (x - mean) / divisor, rounded toward zero
  function automatic logic [MEAN_W-1:0] nudge_mean(logic [MEAN_W-1:0] avg,
                                                   logic [SMP_W-1:0] x,
                                                   longint divisor);
    longint aim, cur, delta;
    aim   = longint'({1'b0, x}) << FRAC_W;
    cur   = longint'({1'b0, avg});
    delta = (aim - cur) / divisor;
    return MEAN_W'(cur + delta);
  endfunction

  // fold one sample pair into the running statistics, return the word it yields
  function automatic stats_t fold_sample(logic [SMP_W-1:0] hum, logic [SMP_W-1:0] temp);
    logic   first;
    longint divisor;
    stats_t word;
    first   = (n_taken == '0);
    divisor = longint'({1'b0, n_taken}) + 1;
    if (first || temp > t_hi) t_hi = temp;
    if (first || temp < t_lo) t_lo = temp;
    if (first || hum > h_hi) h_hi = hum;
    if (first || hum < h_lo) h_lo = hum;
    t_avg = nudge_mean(t_avg, temp, divisor);
    h_avg = nudge_mean(h_avg, hum, divisor);
    // count holds at its top value
    if (n_taken != '1) n_taken = n_taken + 1'b1;
    word.t_min  = t_lo;
    word.t_max  = t_hi;
    word.t_mean = t_avg;
    word.h_min  = h_lo;
    word.h_max  = h_hi;
    word.h_mean = h_avg;
    word.count  = n_taken;
    return word;
  endfunction

  task automatic report_fault(string msg);
    fault_count++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_fault($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // input driver: holds the word while stalled, random gaps between words
  always @(posedge clk) begin : feeder
    sample_t nxt;
    logic    free;
    if (!rst_n) begin
      in_valid <= 1'b0;
      feed_gap <= 0;
    end else begin
      if (in_valid && !in_stall)
        stats_due.push_back(fold_sample(in_humidity_sample, in_temperature_sample));
      calm_tail <= (sample_queue.size() <= CALM_ITEMS);
      free = !in_valid || !in_stall;
      if (free) begin
        if (feed_gap > 0) begin
          feed_gap <= feed_gap - 1;
          in_valid <= 1'b0;
        end else if (sample_queue.size() > 0 && !calm_tail && $urandom_range(0, 9) == 0) begin
          feed_gap <= $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else if (sample_queue.size() > 0) begin
          nxt = sample_queue.pop_front();
          in_valid              <= 1'b1;
          in_humidity_sample    <= nxt.hum;
          in_temperature_sample <= nxt.temp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin : watcher
    stats_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (stats_due.size() == 0) begin
        report_fault("result word with nothing expected");
      end else begin
        want = stats_due.pop_front();
        check_field("temperature_min", 64'(out_temperature_min), 64'(want.t_min));
        check_field("temperature_max", 64'(out_temperature_max), 64'(want.t_max));
        check_field("temperature_mean", 64'(out_temperature_mean), 64'(want.t_mean));
        check_field("humidity_min", 64'(out_humidity_min), 64'(want.h_min));
        check_field("humidity_max", 64'(out_humidity_max), 64'(want.h_max));
        check_field("humidity_mean", 64'(out_humidity_mean), 64'(want.h_mean));
        check_field("sample_count", 64'(out_sample_count), 64'(want.count));
      end
    end
  end

  // stimulus, reset and end of run
  initial begin : stimulus
    sample_t          s;
    int               mode;
    logic [SMP_W-1:0] ph, pt;
    // directed: first word seeds min/max, then extremes and bit patterns
    sample_queue.push_back('{hum: 13'd4000, temp: 13'd4000});
    sample_queue.push_back('{hum: SMP_TOP, temp: '0});
    sample_queue.push_back('{hum: '0, temp: SMP_TOP});
    sample_queue.push_back('{hum: '0, temp: '0});
    sample_queue.push_back('{hum: SMP_TOP, temp: SMP_TOP});
    sample_queue.push_back('{hum: 13'h1555, temp: 13'h0aaa});
    sample_queue.push_back('{hum: 13'h0aaa, temp: 13'h1555});
    sample_queue.push_back('{hum: 13'd1, temp: SMP_TOP - 1'b1});
    sample_queue.push_back('{hum: SMP_TOP - 1'b1, temp: 13'd1});
    sample_queue.push_back('{hum: 13'h1000, temp: 13'h0fff});
    sample_queue.push_back('{hum: 13'h0fff, temp: 13'h1000});
    sample_queue.push_back('{hum: 13'd0, temp: 13'd0});
    sample_queue.push_back('{hum: SMP_TOP, temp: SMP_TOP});
    ph = SMP_TOP;
    pt = SMP_TOP;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      mode = $urandom_range(0, 9);
      if (mode < 5) begin
        s.hum  = SMP_W'($urandom);
        s.temp = SMP_W'($urandom);
      end else if (mode < 7) begin
        // pinned to the rails so min and max hit their ends again
        s.hum  = $urandom_range(0, 1) ? SMP_TOP - SMP_W'($urandom_range(0, 2))
                                      : SMP_W'($urandom_range(0, 2));
        s.temp = $urandom_range(0, 1) ? SMP_TOP - SMP_W'($urandom_range(0, 2))
                                      : SMP_W'($urandom_range(0, 2));
      end else begin
        // small steps from the last word, tiny mean deltas of either sign
        s.hum  = ph + SMP_W'($urandom_range(0, 8)) - SMP_W'(4);
        s.temp = pt + SMP_W'($urandom_range(0, 8)) - SMP_W'(4);
      end
      ph = s.hum;
      pt = s.temp;
      sample_queue.push_back(s);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (sample_queue.size() != 0 || in_valid || stats_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    // every word sent must have come back
    if (stats_due.size() != 0 || in_valid)
      report_fault("result words missing at end of run");
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
hdl/dsmmm_pkg.sv
hdl/dsmmm_div.sv
hdl/dual_sensor_min_max_mean_core.sv
hdl/dsmmm_chk.sv
bench/dual_sensor_min_max_mean_core_tb.sv
